### rtl/indexed_min_heap_queue_defines.svh
// Assertion macros used by the heap queue controller.
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IMHQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, checked out of reset.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

### rtl/imhq_pkg.sv
// Types, constants and helpers for the indexed min-heap queue.
`default_nettype none
package imhq_pkg;
    localparam int unsigned DEPTH  = 1024;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned CW     = $clog2(DEPTH + 1);
    localparam int unsigned KEY_W  = 10;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned PRIO_W = 32;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_EDIT   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADKEY = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
        logic [AW-1:0]     key;
    } t_cell;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_result;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        t_cell         data;
    } t_cell_wr;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [AW-1:0] pos;
    } t_kp_wr;

    function automatic logic [KEY_W-1:0] to_key(input logic [AW-1:0] k);
        logic [31:0] t;
        t = 32'(k);
        return t[KEY_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[CNT_W-1:0];
    endfunction

    function automatic logic [AW-1:0] key_addr(input logic [KEY_W-1:0] k);
        logic [31:0] t;
        t = 32'(k);
        return t[AW-1:0];
    endfunction

    function automatic logic prio_le(input logic [PRIO_W-1:0] a, input logic [PRIO_W-1:0] b);
        return $signed(a) <= $signed(b);
    endfunction
endpackage
`default_nettype wire

### rtl/imhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imhq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/imhq_ctrl.sv
// Heap sequencer: clearing pass, insert, remove-min and change-priority walks.
`default_nettype none
`include "indexed_min_heap_queue_defines.svh"
module imhq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_op,
    input  wire logic [imhq_pkg::PRIO_W-1:0]   i_prio,
    input  wire logic [imhq_pkg::DATA_W-1:0]   i_data,
    input  wire logic [imhq_pkg::KEY_W-1:0]    i_key,
    input  wire logic [imhq_pkg::CW-1:0]       i_limit,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output imhq_pkg::t_result                  o_res,
    output imhq_pkg::t_cell_wr                 o_cell_wr,
    output logic [imhq_pkg::AW-1:0]            o_cell_raddr,
    input  wire imhq_pkg::t_cell               i_cell_rdata,
    output imhq_pkg::t_kp_wr                   o_kp_wr,
    output logic [imhq_pkg::AW-1:0]            o_kp_raddr,
    input  wire logic [imhq_pkg::AW-1:0]       i_kp_rdata
);
    import imhq_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR    = 15'h0001,
        S_IDLE     = 15'h0002,
        S_INS_RD   = 15'h0004,
        S_SWIM     = 15'h0008,
        S_SWIM_CMP = 15'h0010,
        S_PLACE    = 15'h0020,
        S_REM_RD0  = 15'h0040,
        S_REM_RD1  = 15'h0080,
        S_SINK     = 15'h0100,
        S_SINK_L   = 15'h0200,
        S_SINK_R   = 15'h0400,
        S_SINK_CMP = 15'h0800,
        S_EDT_KP   = 15'h1000,
        S_EDT_RD   = 15'h2000,
        S_DONE     = 15'h4000
    } t_state;

    t_state            r_state, n_state;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [DATA_W-1:0] r_data, n_data;
    t_cell             r_cur, n_cur;
    t_cell             r_aux, n_aux;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_cidx, n_cidx;
    logic [CW-1:0]     r_lim, n_lim;
    logic [CW-1:0]     r_count, n_count;
    t_result           r_res, n_res;
    logic [AW-1:0]     r_clr, n_clr;

    logic [CW:0]       w_child;
    logic [CW:0]       w_child1;
    logic [CW-1:0]     w_parent;
    logic [CW-1:0]     w_last;
    logic              w_key_ok;

    assign w_child  = {r_pos, 1'b1};
    assign w_child1 = w_child + 1'b1;
    assign w_parent = (r_pos - 1'b1) >> 1;
    assign w_last   = r_count - 1'b1;
    assign w_key_ok = 32'(i_key) < DEPTH;

    always_comb begin
        n_state      = r_state;
        n_prio       = r_prio;
        n_data       = r_data;
        n_cur        = r_cur;
        n_aux        = r_aux;
        n_pos        = r_pos;
        n_cidx       = r_cidx;
        n_lim        = r_lim;
        n_count      = r_count;
        n_res        = r_res;
        n_clr        = r_clr;
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_cell_wr    = '0;
        o_kp_wr      = '0;
        o_cell_raddr = '0;
        o_kp_raddr   = '0;
        case (r_state)
            S_CLEAR: begin
                // write identity keys into both tables
                o_cell_wr = '{we: 1'b1, addr: r_clr, data: '{prio: '0, data: '0, key: r_clr}};
                o_kp_wr   = '{we: 1'b1, addr: r_clr, pos: r_clr};
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_prio = i_prio;
                    n_data = i_data;
                    n_res  = '0;
                    case (i_op)
                        OP_INSERT: begin
                            if (r_count >= i_limit) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                o_cell_raddr = r_count[AW-1:0];
                                n_state      = S_INS_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                o_cell_raddr = '0;
                                n_state      = S_REM_RD0;
                            end
                        end
                        OP_EDIT: begin
                            if (w_key_ok) begin
                                o_kp_raddr = key_addr(i_key);
                                n_state    = S_EDT_KP;
                            end else begin
                                n_res.status = ST_BADKEY;
                                n_state      = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD: begin
                n_cur     = '{prio: r_prio, data: r_data, key: i_cell_rdata.key};
                n_res.key = to_key(i_cell_rdata.key);
                n_pos     = r_count;
                n_count   = r_count + 1'b1;
                n_state   = S_SWIM;
            end
            S_REM_RD0: begin
                n_aux        = i_cell_rdata;
                n_res.key    = to_key(i_cell_rdata.key);
                n_res.prio   = i_cell_rdata.prio;
                n_res.data   = i_cell_rdata.data;
                o_cell_raddr = w_last[AW-1:0];
                n_state      = S_REM_RD1;
            end
            S_REM_RD1: begin
                // park the old root in the last slot, sink the last cell from the top
                n_cur     = i_cell_rdata;
                o_cell_wr = '{we: 1'b1, addr: w_last[AW-1:0], data: r_aux};
                o_kp_wr   = '{we: 1'b1, addr: r_aux.key, pos: w_last[AW-1:0]};
                n_pos     = '0;
                n_lim     = w_last;
                n_count   = w_last;
                n_state   = S_SINK;
            end
            S_EDT_KP: begin
                if (CW'(i_kp_rdata) >= r_count) begin
                    n_res.status = ST_BADKEY;
                    n_state      = S_DONE;
                end else begin
                    o_cell_raddr = i_kp_rdata;
                    n_pos        = CW'(i_kp_rdata);
                    n_state      = S_EDT_RD;
                end
            end
            S_EDT_RD: begin
                n_cur = '{prio: r_prio, data: i_cell_rdata.data, key: i_cell_rdata.key};
                n_lim = r_count;
                if (prio_le(r_prio, i_cell_rdata.prio)) begin
                    n_state = S_SWIM;
                end else begin
                    n_state = S_SINK;
                end
            end
            S_SWIM: begin
                if (r_pos == '0) begin
                    n_state = S_PLACE;
                end else begin
                    o_cell_raddr = w_parent[AW-1:0];
                    n_cidx       = w_parent;
                    n_state      = S_SWIM_CMP;
                end
            end
            S_SWIM_CMP: begin
                if (prio_le(r_cur.prio, i_cell_rdata.prio)) begin
                    // drop the parent into the hole and move up
                    o_cell_wr = '{we: 1'b1, addr: r_pos[AW-1:0], data: i_cell_rdata};
                    o_kp_wr   = '{we: 1'b1, addr: i_cell_rdata.key, pos: r_pos[AW-1:0]};
                    n_pos     = r_cidx;
                    n_state   = S_SWIM;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SINK: begin
                if (w_child >= {1'b0, r_lim}) begin
                    n_state = S_PLACE;
                end else begin
                    o_cell_raddr = w_child[AW-1:0];
                    n_cidx       = w_child[CW-1:0];
                    n_state      = S_SINK_L;
                end
            end
            S_SINK_L: begin
                n_aux = i_cell_rdata;
                if (w_child1 < {1'b0, r_lim}) begin
                    o_cell_raddr = w_child1[AW-1:0];
                    n_state      = S_SINK_R;
                end else begin
                    n_state = S_SINK_CMP;
                end
            end
            S_SINK_R: begin
                // right child wins ties
                if (prio_le(i_cell_rdata.prio, r_aux.prio)) begin
                    n_aux  = i_cell_rdata;
                    n_cidx = r_cidx + 1'b1;
                end
                n_state = S_SINK_CMP;
            end
            S_SINK_CMP: begin
                if (prio_le(r_cur.prio, r_aux.prio)) begin
                    n_state = S_PLACE;
                end else begin
                    o_cell_wr = '{we: 1'b1, addr: r_pos[AW-1:0], data: r_aux};
                    o_kp_wr   = '{we: 1'b1, addr: r_aux.key, pos: r_pos[AW-1:0]};
                    n_pos     = r_cidx;
                    n_state   = S_SINK;
                end
            end
            S_PLACE: begin
                o_cell_wr = '{we: 1'b1, addr: r_pos[AW-1:0], data: r_cur};
                o_kp_wr   = '{we: 1'b1, addr: r_cur.key, pos: r_pos[AW-1:0]};
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res       = r_res;
        o_res.count = to_cnt(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
        end
        r_prio <= n_prio;
        r_data <= n_data;
        r_cur  <= n_cur;
        r_aux  <= n_aux;
        r_pos  <= n_pos;
        r_cidx <= n_cidx;
        r_lim  <= n_lim;
        r_res  <= n_res;
    end

    `IMHQ_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, !o_in_ready)
    `IMHQ_ASSERT_NEXT(a_swim_moves_up, (r_state == S_SWIM_CMP) && o_cell_wr.we,
                      r_pos < $past(r_pos))
    `IMHQ_ASSERT_IMPL(a_count_bounded, r_state == S_DONE, 32'(r_count) <= DEPTH)
    `IMHQ_ASSERT_NEXT(a_result_taken, o_res_valid && i_res_ready, r_state == S_IDLE)
endmodule
`default_nettype wire

### rtl/indexed_min_heap_queue.sv
// One item is in work at a time; every step of a walk waits on one cell RAM read.
// A result waits in the output register while the next item is accepted.
// Reset: synchronous, active low; a clearing pass writes identity keys into
// both tables, and no item is accepted until it ends.
`default_nettype none
module indexed_min_heap_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // priority_req, payload, item_key, zero fill
    input  wire logic [1:0]  s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,  // out_key, out_priority, out_payload, count, fill
    output logic [1:0]       m_axis_tuser   // status
);
    import imhq_pkg::*;

    logic [10:0]   r_cap;
    logic [CW-1:0] w_limit;
    logic          w_res_valid;
    logic          w_res_ready;
    t_result       w_res;
    t_result       r_out;
    logic          r_ovalid;
    t_cell_wr      w_cell_wr;
    logic [AW-1:0] w_cell_raddr;
    t_cell         w_cell_rdata;
    t_kp_wr        w_kp_wr;
    logic [AW-1:0] w_kp_raddr;
    logic [AW-1:0] w_kp_rdata;

    assign w_limit = (32'(r_cap) < DEPTH) ? CW'(r_cap) : CW'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 11'd1024;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    imhq_ram #(.WIDTH($bits(t_cell)), .DEPTH(DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_wr.we),
        .i_waddr (w_cell_wr.addr),
        .i_wdata (w_cell_wr.data),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    imhq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_kp_ram (
        .i_clk   (i_clk),
        .i_we    (w_kp_wr.we),
        .i_waddr (w_kp_wr.addr),
        .i_wdata (w_kp_wr.pos),
        .i_raddr (w_kp_raddr),
        .o_rdata (w_kp_rdata)
    );

    imhq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_prio       (s_axis_tdata[31:0]),
        .i_data       (s_axis_tdata[63:32]),
        .i_key        (s_axis_tdata[73:64]),
        .i_limit      (w_limit),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_cell_wr    (w_cell_wr),
        .o_cell_raddr (w_cell_raddr),
        .i_cell_rdata (w_cell_rdata),
        .o_kp_wr      (w_kp_wr),
        .o_kp_raddr   (w_kp_raddr),
        .i_kp_rdata   (w_kp_rdata)
    );

    // load the output register when it is empty or being drained
    assign w_res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_ready) begin
            r_ovalid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {3'b000, r_out.count, r_out.data, r_out.prio, r_out.key};
endmodule
`default_nettype wire
